>>> src/kmeans_lloyd_clustering_top_macros.svh
// Assertion helpers shared by the clustering block
`ifndef KMEANS_LLOYD_CLUSTERING_TOP_MACROS_SVH
`define KMEANS_LLOYD_CLUSTERING_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KML_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define KML_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/kml_pkg.sv
package kml_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_LOAD_POINT  = 2'd0,
    OP_LOAD_CENTER = 2'd1,
    OP_RUN         = 2'd2,
    OP_READ        = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_NUM_POINTS   = 2'd0;
  localparam logic [1:0] REG_NUM_CLUSTERS = 2'd1;
  localparam logic [1:0] REG_STOP_SHIFT   = 2'd2;
  localparam logic [1:0] REG_MAX_ITERS    = 2'd3;

  // Configuration reset values
  localparam logic [12:0] NUM_POINTS_RST   = 13'd4096;
  localparam logic [4:0]  NUM_CLUSTERS_RST = 5'd11;
  localparam logic [3:0]  STOP_SHIFT_RST   = 4'd10;
  localparam logic [15:0] MAX_ITERS_RST    = 16'd1000;

  // Result kinds
  localparam logic KIND_CENTROID = 1'b0;
  localparam logic KIND_GROUP    = 1'b1;

  // Sequencer states
  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_RD_OUT  = 14'b00000000000010,
    ST_P_ADDR  = 14'b00000000000100,
    ST_D_X     = 14'b00000000001000,
    ST_D_Y     = 14'b00000000010000,
    ST_D_CMP   = 14'b00000000100000,
    ST_P_WRITE = 14'b00000001000000,
    ST_CLR     = 14'b00000010000000,
    ST_A_ADDR  = 14'b00000100000000,
    ST_A_ADD   = 14'b00001000000000,
    ST_M_START = 14'b00010000000000,
    ST_M_X     = 14'b00100000000000,
    ST_M_Y     = 14'b01000000000000,
    ST_EMIT    = 14'b10000000000000
  } state_t;

endpackage

>>> src/kml_div.sv
module kml_div #(
  parameter int DW = 45,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import kml_pkg::*;

  localparam int NW = $clog2(DW + 1);

  logic          busy;
  logic [NW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW:0]   shifted;
  logic [VW+1:0] trial;
  logic          fits;

  // Restoring step: one quotient bit per cycle
  assign shifted = {rem, quo[DW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = !trial[VW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(DW);
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: hold quotient once finished
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> src/kmeans_lloyd_clustering_top.sv
// Two-dimensional k-means clustering engine (Lloyd iteration, Q16.16).
// Request channel (in_valid/in_ready): operation, item_index, x_coord,
// y_coord. Loads of a point or centroid are written on acceptance; a read
// of a point's group returns one result through the result register.
// A run request returns num_clusters centroid records (clamped to
// 1..MAX_CLUSTERS), the last one flagged by last_result. The block
// takes no request while a run is busy. Each assignment pass squares
// dx then dy in one shared multiplier, then compares per centroid; each
// accumulate pass adds every point; each mean step divides x and y per
// non-empty centroid in the bit-serial divider and skips an empty one.
// A run is the initial pass plus, per iteration, accumulate + means +
// reassignment, then a final counting pass and k output records.
// Config channel (cfg_valid/cfg_ready, always ready): the user writes only while idle; the block does not enforce it.
// Reset (rst, synchronous) restores register defaults and clears the
// sequencer; point and centroid stores hold garbage until loaded.
// A stalled result channel (out_ready low) holds the result register and
// pauses centroid output; requests are taken again once the last record
// sits in the result register.
module kmeans_lloyd_clustering_top #(
  parameter int MAX_POINTS   = 4096,
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [11:0]           item_index,
  input  logic [COORD_BITS-1:0] x_coord,
  input  logic [COORD_BITS-1:0] y_coord,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  result_kind,
  output logic [11:0]           result_index,
  output logic [COORD_BITS-1:0] centroid_x,
  output logic [COORD_BITS-1:0] centroid_y,
  output logic [12:0]           member_count,
  output logic [15:0]           iterations_done,
  output logic                  last_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import kml_pkg::*;
  `include "kmeans_lloyd_clustering_top_macros.svh"

  localparam int CB  = COORD_BITS;
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int CW  = $clog2(MAX_CLUSTERS);
  localparam int KW  = $clog2(MAX_CLUSTERS + 1);
  localparam int SW  = CB + PAW;
  localparam int DW  = SW + 1;
  localparam int MW  = CB + 1;
  localparam int PW  = 2 * MW;
  localparam int DSW = PW + 1;

  state_t state;

  // Configuration registers
  logic [12:0] num_points;
  logic [4:0]  num_clusters;
  logic [3:0]  stop_shift;
  logic [15:0] max_iterations;

  // Point stores
  logic [CB-1:0] pt_x_mem [MAX_POINTS];
  logic [CB-1:0] pt_y_mem [MAX_POINTS];
  logic [CW-1:0] grp_mem  [MAX_POINTS];
  logic [CB-1:0] px_rd;
  logic [CB-1:0] py_rd;
  logic [CW-1:0] grp_rd;

  // Centroids and accumulators
  logic [CB-1:0]  cx_reg  [MAX_CLUSTERS];
  logic [CB-1:0]  cy_reg  [MAX_CLUSTERS];
  logic [SW-1:0]  sum_x   [MAX_CLUSTERS];
  logic [SW-1:0]  sum_y   [MAX_CLUSTERS];
  logic [PCW-1:0] cnt_reg [MAX_CLUSTERS];

  // Sequencer counters
  logic [PCW-1:0] p;
  logic [CW-1:0]  c;
  logic [15:0]    iters;
  logic [PCW-1:0] changes;
  logic           first_pass;
  logic           final_pass;
  logic           rd_oob;

  // Distance unit
  logic [PW-1:0]  prod;
  logic [PW-1:0]  dx2;
  logic [DSW-1:0] best_d;
  logic [CW-1:0]  best_idx;

  logic           accept;
  logic           out_free;
  logic           out_load;
  logic [PCW-1:0] n_eff;
  logic [KW-1:0]  k_eff;
  logic [16:0]    lim;
  logic           c_last;
  logic           p_last;
  logic [PCW-1:0] thr;
  logic           chg_inc;
  logic [PCW-1:0] chg_sum;
  logic           keep_going;
  logic [MW-1:0]  diff;
  logic [MW-1:0]  mag;
  logic [DSW-1:0] cand_d;
  logic           pt_ok;
  logic           ct_ok;
  logic           pt_re;
  logic [PAW-1:0] pt_ra;

  // Mean unit
  logic           div_start;
  logic           div_done;
  logic [DW-1:0]  div_quo;
  logic [SW-1:0]  sum_sel;
  logic           sel_neg;
  logic [SW-1:0]  sum_mag;
  logic [DW-1:0]  dividend;
  logic           res_neg;
  logic [CB-1:0]  mean;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = ((state == ST_RD_OUT) || (state == ST_EMIT)) && out_free;

  // Effective run limits
  assign n_eff = (32'(num_points) > MAX_POINTS) ? PCW'(MAX_POINTS) : PCW'(num_points);
  always_comb begin
    if (num_clusters == 5'd0) begin
      k_eff = KW'(1);
    end else if (32'(num_clusters) > MAX_CLUSTERS) begin
      k_eff = KW'(MAX_CLUSTERS);
    end else begin
      k_eff = KW'(num_clusters);
    end
  end
  assign lim    = (max_iterations == 16'd0) ? 17'd1 : {1'b0, max_iterations};
  assign c_last = (KW'(c) == k_eff - KW'(1));
  assign p_last = (p == n_eff - PCW'(1));
  assign thr    = n_eff >> stop_shift;

  // Stop test on the change count including this point and on the iteration limit
  assign chg_inc    = (state == ST_P_WRITE) && !first_pass && (best_idx != grp_rd);
  assign chg_sum    = changes + PCW'(chg_inc);
  assign keep_going = (chg_sum > thr) && (({1'b0, iters} + 17'd1) < lim);

  assign pt_ok = 32'(item_index) < MAX_POINTS;
  assign ct_ok = 32'(item_index) < MAX_CLUSTERS;

  // Shared squaring: dx in ST_D_X, dy in ST_D_Y
  always_comb begin
    if (state == ST_D_Y) begin
      diff = $signed({py_rd[CB-1], py_rd}) - $signed({cy_reg[c][CB-1], cy_reg[c]});
    end else begin
      diff = $signed({px_rd[CB-1], px_rd}) - $signed({cx_reg[c][CB-1], cx_reg[c]});
    end
    mag = diff[MW-1] ? (MW'(0) - diff) : diff;
  end
  assign cand_d = DSW'(dx2) + DSW'(prod);

  always_ff @(posedge clk) begin
    if ((state == ST_D_X) || (state == ST_D_Y)) begin
      prod <= mag * mag;
    end
    if (state == ST_D_Y) begin
      dx2 <= prod;
    end
    if ((state == ST_D_CMP) && ((c == CW'(0)) || (cand_d < best_d))) begin
      best_d   <= cand_d;
      best_idx <= c;
    end
  end

  // Point memories: one write port, one registered read port
  assign pt_re = (accept && (operation == OP_READ)) || (state == ST_P_ADDR) ||
                 (state == ST_A_ADDR);
  assign pt_ra = (state == ST_IDLE) ? PAW'(item_index) : p[PAW-1:0];

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_LOAD_POINT) && pt_ok) begin
      pt_x_mem[PAW'(item_index)] <= x_coord;
      pt_y_mem[PAW'(item_index)] <= y_coord;
    end
    if (pt_re) begin
      px_rd <= pt_x_mem[pt_ra];
      py_rd <= pt_y_mem[pt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_P_WRITE) begin
      grp_mem[p[PAW-1:0]] <= best_idx;
    end
    if (pt_re) begin
      grp_rd <= grp_mem[pt_ra];
    end
  end

  // Mean: rounded |sum| / count through the bit-serial divider
  assign sum_sel  = (state == ST_M_X) ? sum_y[c] : sum_x[c];
  assign sel_neg  = sum_sel[SW-1];
  assign sum_mag  = sel_neg ? (SW'(0) - sum_sel) : sum_sel;
  assign dividend = DW'(sum_mag) + DW'(cnt_reg[c] >> 1);
  assign div_start = ((state == ST_M_START) && (cnt_reg[c] != PCW'(0))) ||
                     ((state == ST_M_X) && div_done);
  assign res_neg  = (state == ST_M_Y) ? sum_y[c][SW-1] : sum_x[c][SW-1];
  assign mean     = res_neg ? (CB'(0) - CB'(div_quo)) : CB'(div_quo);

  kml_div #(
    .DW(DW),
    .VW(PCW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (cnt_reg[c]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Centroid registers: loaded by request, updated by the mean step
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_LOAD_CENTER) && ct_ok) begin
      cx_reg[CW'(item_index)] <= x_coord;
      cy_reg[CW'(item_index)] <= y_coord;
    end
    if ((state == ST_M_X) && div_done) begin
      cx_reg[c] <= mean;
    end
    if ((state == ST_M_Y) && div_done) begin
      cy_reg[c] <= mean;
    end
  end

  // Accumulators: clear per iteration, add one point per pass step
  always_ff @(posedge clk) begin
    if (rst || (state == ST_CLR)) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        sum_x[i]   <= '0;
        sum_y[i]   <= '0;
        cnt_reg[i] <= '0;
      end
    end else if (state == ST_A_ADD) begin
      sum_x[grp_rd]   <= sum_x[grp_rd] + SW'($signed(px_rd));
      sum_y[grp_rd]   <= sum_y[grp_rd] + SW'($signed(py_rd));
      cnt_reg[grp_rd] <= cnt_reg[grp_rd] + PCW'(1);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      num_points     <= NUM_POINTS_RST;
      num_clusters   <= NUM_CLUSTERS_RST;
      stop_shift     <= STOP_SHIFT_RST;
      max_iterations <= MAX_ITERS_RST;
      p              <= '0;
      c              <= '0;
      iters          <= '0;
      changes        <= '0;
      first_pass     <= 1'b0;
      final_pass     <= 1'b0;
      rd_oob         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_NUM_POINTS:   num_points     <= cfg_data[12:0];
          REG_NUM_CLUSTERS: num_clusters   <= cfg_data[4:0];
          REG_STOP_SHIFT:   stop_shift     <= cfg_data[3:0];
          REG_MAX_ITERS:    max_iterations <= cfg_data;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && (operation == OP_READ)) begin
            rd_oob <= !pt_ok;
            state  <= ST_RD_OUT;
          end else if (accept && (operation == OP_RUN)) begin
            p          <= '0;
            c          <= '0;
            iters      <= '0;
            changes    <= '0;
            first_pass <= 1'b1;
            final_pass <= 1'b0;
            state      <= ST_P_ADDR;
          end
        end
        ST_RD_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_P_ADDR: begin
          c <= '0;
          if (n_eff == PCW'(0)) begin
            p <= '0;
            state <= ST_CLR;
            if (!first_pass) begin
              iters      <= iters + 16'd1;
              final_pass <= !keep_going;
            end
            first_pass <= 1'b0;
          end else begin
            state <= ST_D_X;
          end
        end
        ST_D_X: state <= ST_D_Y;
        ST_D_Y: state <= ST_D_CMP;
        ST_D_CMP: begin
          if (c_last) begin
            state <= ST_P_WRITE;
          end else begin
            c     <= c + CW'(1);
            state <= ST_D_X;
          end
        end
        ST_P_WRITE: begin
          changes <= chg_sum;
          if (p_last) begin
            p <= '0;
            state <= ST_CLR;
            if (!first_pass) begin
              iters      <= iters + 16'd1;
              final_pass <= !keep_going;
            end
            first_pass <= 1'b0;
          end else begin
            p     <= p + PCW'(1);
            state <= ST_P_ADDR;
          end
        end
        ST_CLR: begin
          p     <= '0;
          state <= ST_A_ADDR;
        end
        ST_A_ADDR: begin
          if (n_eff == PCW'(0)) begin
            c     <= '0;
            state <= final_pass ? ST_EMIT : ST_M_START;
          end else begin
            state <= ST_A_ADD;
          end
        end
        ST_A_ADD: begin
          if (p_last) begin
            c     <= '0;
            state <= final_pass ? ST_EMIT : ST_M_START;
          end else begin
            p     <= p + PCW'(1);
            state <= ST_A_ADDR;
          end
        end
        ST_M_START: begin
          if (cnt_reg[c] != PCW'(0)) begin
            state <= ST_M_X;
          end else if (c_last) begin
            p       <= '0;
            c       <= '0;
            changes <= '0;
            state   <= ST_P_ADDR;
          end else begin
            c <= c + CW'(1);
          end
        end
        ST_M_X: begin
          if (div_done) begin
            state <= ST_M_Y;
          end
        end
        ST_M_Y: begin
          if (div_done) begin
            if (c_last) begin
              p       <= '0;
              c       <= '0;
              changes <= '0;
              state   <= ST_P_ADDR;
            end else begin
              c     <= c + CW'(1);
              state <= ST_M_START;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (c_last) begin
              state <= ST_IDLE;
            end else begin
              c <= c + CW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_RD_OUT) begin
        result_kind     <= KIND_GROUP;
        result_index    <= rd_oob ? 12'd0 : 12'(grp_rd);
        centroid_x      <= '0;
        centroid_y      <= '0;
        member_count    <= '0;
        iterations_done <= '0;
        last_result     <= 1'b1;
      end else begin
        result_kind     <= KIND_CENTROID;
        result_index    <= 12'(c);
        centroid_x      <= cx_reg[c];
        centroid_y      <= cy_reg[c];
        member_count    <= 13'(cnt_reg[c]);
        iterations_done <= iters;
        last_result     <= c_last;
      end
    end
  end

  `KML_ASSERT_IMP(a_div_in_mean, div_done, (state == ST_M_X) || (state == ST_M_Y), "stray divide")
  `KML_ASSERT_NXT(a_last_ends_run, (state == ST_EMIT) && out_free && c_last, state == ST_IDLE, "run open")
  `KML_ASSERT_IMP(a_changes_bound, state == ST_P_WRITE, changes < n_eff, "change count exceeds point count")
  `KML_ASSERT_IMP(a_group_range, state == ST_P_WRITE, KW'(best_idx) < k_eff, "group beyond cluster count")

endmodule
